>>> sv/atf_pkg.sv
package atf_pkg;

    localparam int SAMPLE_W   = 13;
    localparam int OFS_W      = 10;
    localparam int CORR_W     = 14;
    localparam int MEAN_W     = 14;
    localparam int SQ_W       = 28;
    localparam int ROOT_W     = 30;
    localparam int REM_W      = 34;
    localparam int SQRT_STEPS = 30;
    localparam int CORD_STEPS = 18;
    localparam int XY_W       = 32;
    localparam int ANG_W      = 25;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = 5;
    localparam int CODE_W     = 8;
    localparam int NUM_AXES   = 3;

    localparam logic [1:0] REG_X_OFS = 2'd0;
    localparam logic [1:0] REG_Y_OFS = 2'd1;
    localparam logic [1:0] REG_Z_OFS = 2'd2;

    localparam logic signed [OFS_W-1:0] X_OFS_RST = 10'sd10;
    localparam logic signed [OFS_W-1:0] Y_OFS_RST = -10'sd27;
    localparam logic signed [OFS_W-1:0] Z_OFS_RST = 10'sd104;

    localparam logic signed [ANG_W-1:0] T_BIAS   = 25'sd5898240;
    localparam logic [CODE_W-1:0]       CODE_MID = 8'd90;
    localparam logic [CODE_W-1:0]       CODE_MAX = 8'd180;
    localparam logic [CODE_W-1:0]       CODE_MIN = 8'd0;

    typedef struct packed {
        logic load;
        logic sum_en;
        logic div_init;
        logic div_step;
        logic sq_en;
        logic sqrt_init;
        logic sqrt_step;
        logic cord_init;
        logic cord_step;
        logic out_load;
    } atf_cmd_t;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic [ANG_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] r;
        unique case (i)
            5'd0:  r = 25'd2949120;
            5'd1:  r = 25'd1740967;
            5'd2:  r = 25'd919879;
            5'd3:  r = 25'd466945;
            5'd4:  r = 25'd234379;
            5'd5:  r = 25'd117304;
            5'd6:  r = 25'd58666;
            5'd7:  r = 25'd29335;
            5'd8:  r = 25'd14668;
            5'd9:  r = 25'd7334;
            5'd10: r = 25'd3667;
            5'd11: r = 25'd1833;
            5'd12: r = 25'd917;
            5'd13: r = 25'd458;
            5'd14: r = 25'd229;
            5'd15: r = 25'd115;
            5'd16: r = 25'd57;
            5'd17: r = 25'd29;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/atf_angle.sv
module atf_angle import atf_pkg::*; (
    input  logic                     aclk,
    input  atf_cmd_t                 cmd,
    input  logic [STEP_W-1:0]        step,
    input  logic signed [MEAN_W-1:0] num,
    input  logic [SQ_W-1:0]          sq_a,
    input  logic [SQ_W-1:0]          sq_b,
    output logic [CODE_W-1:0]        code
);

    logic [SQ_W-1:0]          rad_reg, rad_next;
    logic                     sq_zero_reg, sq_zero_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;

    logic [REM_W-1:0]         rem_sh, trial;
    logic signed [XY_W-1:0]   xs, ys;
    logic [MEAN_W-1:0]        num_mag;
    logic signed [ANG_W-1:0]  t;
    logic [ANG_W-FRAC_W-1:0]  t_int;

    always_comb begin
        rem_sh  = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1:SQ_W-2]};
        trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};
        xs      = x_reg >>> step;
        ys      = y_reg >>> step;
        num_mag = num[MEAN_W-1] ? MEAN_W'(-num) : MEAN_W'(num);

        rad_next     = rad_reg;
        sq_zero_next = sq_zero_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;

        if (cmd.sqrt_init) begin
            rad_next     = sq_a + sq_b;
            sq_zero_next = (sq_a + sq_b) == '0;
            rem_next     = '0;
            root_next    = '0;
        end else if (cmd.sqrt_step) begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end

        if (cmd.cord_init) begin
            x_next = XY_W'(root_reg);
            y_next = XY_W'(num_mag) <<< FRAC_W;
            z_next = '0;
        end else if (cmd.cord_step) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + $signed(atan_deg(step));
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - $signed(atan_deg(step));
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg     <= rad_next;
        sq_zero_reg <= sq_zero_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
    end

    always_comb begin
        t     = (num > 0) ? (T_BIAS + z_reg) : (T_BIAS - z_reg);
        t_int = t[ANG_W-1:FRAC_W];
        priority if (num == '0) begin
            code = CODE_MID;
        end else if (sq_zero_reg) begin
            code = (num > 0) ? CODE_MAX : CODE_MIN;
        end else if (t[ANG_W-1]) begin
            code = CODE_MIN;
        end else if (t_int > (ANG_W-FRAC_W)'(CODE_MAX)) begin
            code = CODE_MAX;
        end else begin
            code = t_int[CODE_W-1:0];
        end
    end

endmodule

>>> sv/atf_datapath.sv
module atf_datapath import atf_pkg::*; #(
    parameter int WINDOW_DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  atf_cmd_t                               cmd,
    input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] wr_slot,
    input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] rd_idx,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      fill,
    input  logic [STEP_W-1:0]                      step,
    input  logic signed [SAMPLE_W-1:0]             s_accel_x,
    input  logic signed [SAMPLE_W-1:0]             s_accel_y,
    input  logic signed [SAMPLE_W-1:0]             s_accel_z,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [OFS_W-1:0]                       cfg_data,
    output logic [CODE_W-1:0]                      m_alpha_code,
    output logic [CODE_W-1:0]                      m_beta_code
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH+1);
    localparam int SUM_W = CORR_W + CNT_W;
    localparam int DV_W  = CNT_W + 1 + SUM_W;

    logic signed [OFS_W-1:0]  ofs_reg [NUM_AXES];
    logic signed [CORR_W-1:0] hist_mem [NUM_AXES][WINDOW_DEPTH];
    logic signed [SUM_W-1:0]  sum_reg [NUM_AXES];
    logic [DV_W-1:0]          dv_reg [NUM_AXES];
    logic [DV_W-1:0]          dv_next [NUM_AXES];
    logic                     neg_reg [NUM_AXES];
    logic signed [MEAN_W-1:0] mean_reg [NUM_AXES];
    logic [SQ_W-1:0]          sq_reg [NUM_AXES];
    logic [CODE_W-1:0]        alpha_reg, beta_reg;
    logic [CODE_W-1:0]        alpha_code, beta_code;

    logic signed [SAMPLE_W-1:0] sample [NUM_AXES];
    logic signed [CORR_W-1:0]   corr [NUM_AXES];
    logic signed [MEAN_W-1:0]   mean [NUM_AXES];
    logic signed [SQ_W-1:0]     prod [NUM_AXES];
    logic [DV_W-1:0]            dv_sh;
    logic [CNT_W:0]             rem_hi;
    logic [SUM_W-1:0]           quo;

    assign sample[0] = s_accel_x;
    assign sample[1] = s_accel_y;
    assign sample[2] = s_accel_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_reg[0] <= X_OFS_RST;
            ofs_reg[1] <= Y_OFS_RST;
            ofs_reg[2] <= Z_OFS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_X_OFS: ofs_reg[0] <= cfg_data;
                REG_Y_OFS: ofs_reg[1] <= cfg_data;
                REG_Z_OFS: ofs_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            corr[a] = {{(CORR_W-SAMPLE_W){sample[a][SAMPLE_W-1]}}, sample[a]}
                    + {{(CORR_W-OFS_W){ofs_reg[a][OFS_W-1]}}, ofs_reg[a]};
        end
    end

    // one restoring division step per cycle on the magnitude
    always_comb begin
        dv_sh  = '0;
        rem_hi = '0;
        quo    = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            dv_next[a] = dv_reg[a];
            if (cmd.div_init) begin
                dv_next[a] = {{(CNT_W+1){1'b0}},
                              sum_reg[a][SUM_W-1] ? SUM_W'(-sum_reg[a]) : SUM_W'(sum_reg[a])};
            end else if (cmd.div_step) begin
                dv_sh  = dv_reg[a] << 1;
                rem_hi = dv_sh[DV_W-1:SUM_W];
                if (rem_hi >= {1'b0, fill}) begin
                    dv_next[a] = {rem_hi - {1'b0, fill}, dv_sh[SUM_W-1:1], 1'b1};
                end else begin
                    dv_next[a] = dv_sh;
                end
            end
            quo     = dv_reg[a][SUM_W-1:0];
            mean[a] = neg_reg[a] ? -$signed(quo[MEAN_W-1:0]) : $signed(quo[MEAN_W-1:0]);
            prod[a] = mean[a] * mean[a];
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (cmd.load) begin
                hist_mem[a][wr_slot] <= corr[a];
                sum_reg[a]           <= '0;
            end else if (cmd.sum_en) begin
                sum_reg[a] <= sum_reg[a]
                            + {{(SUM_W-CORR_W){hist_mem[a][rd_idx][CORR_W-1]}},
                               hist_mem[a][rd_idx]};
            end
            if (cmd.div_init) begin
                neg_reg[a] <= sum_reg[a][SUM_W-1];
            end
            dv_reg[a] <= dv_next[a];
            if (cmd.sq_en) begin
                mean_reg[a] <= mean[a];
                sq_reg[a]   <= $unsigned(prod[a]);
            end
        end
        if (cmd.out_load) begin
            alpha_reg <= alpha_code;
            beta_reg  <= beta_code;
        end
    end

    atf_angle u_alpha (
        .aclk (aclk),
        .cmd  (cmd),
        .step (step),
        .num  (mean_reg[0]),
        .sq_a (sq_reg[1]),
        .sq_b (sq_reg[2]),
        .code (alpha_code)
    );

    atf_angle u_beta (
        .aclk (aclk),
        .cmd  (cmd),
        .step (step),
        .num  (mean_reg[1]),
        .sq_a (sq_reg[0]),
        .sq_b (sq_reg[2]),
        .code (beta_code)
    );

    assign m_alpha_code = alpha_reg;
    assign m_beta_code  = beta_reg;

endmodule

>>> sv/atf_ctrl.sv
module atf_ctrl import atf_pkg::*; #(
    parameter int WINDOW_DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output atf_cmd_t                               cmd,
    output logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] wr_slot,
    output logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] rd_idx,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]      fill,
    output logic [STEP_W-1:0]                      step
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH+1);
    localparam int SUM_W = CORR_W + CNT_W;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SUM   = 10'b0000000010,
        ST_DINIT = 10'b0000000100,
        ST_DIV   = 10'b0000001000,
        ST_SQR   = 10'b0000010000,
        ST_SINIT = 10'b0000100000,
        ST_SQRT  = 10'b0001000000,
        ST_CINIT = 10'b0010000000,
        ST_CORD  = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                m_valid_reg, m_valid_next;
    logic                accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg + 1'b1;
        slot_next    = slot_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                    slot_next  = (slot_reg == IDX_W'(WINDOW_DEPTH-1)) ? '0 : slot_reg + 1'b1;
                    if (fill_reg != CNT_W'(WINDOW_DEPTH)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                if (cnt_reg == STEP_W'(fill_reg - 1'b1)) begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_W'(SUM_W-1)) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                cmd.sq_en  = 1'b1;
                state_next = ST_SINIT;
            end
            ST_SINIT: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS-1)) begin
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT: begin
                cmd.cord_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_CORD;
            end
            ST_CORD: begin
                cmd.cord_step = 1'b1;
                if (cnt_reg == STEP_W'(CORD_STEPS-1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            slot_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign wr_slot = slot_reg;
    assign rd_idx  = cnt_reg[IDX_W-1:0];
    assign fill    = fill_reg;
    assign step    = cnt_reg;

endmodule

>>> sv/accel_tilt_angle_filter.sv
// Tilt-angle filter: each accepted transaction carries one x/y/z sample in
// milli-g; a calibration offset is added per axis, the result enters a
// WINDOW_DEPTH-deep history, and the truncated mean over the filled entries
// feeds two tilt angles (atan2 via a 30-step square root and an 18-step
// CORDIC), returned as degree codes 0..180 with 90 meaning level. Items are
// processed one at a time; the time from acceptance to the result register is
// set by the serial window sum over the filled entries, the bit-serial
// divider, the square root and the CORDIC. The next sample can be accepted
// once the result is loaded, while the result waits in its output register.
// Offsets are written through cfg_we/cfg_index/cfg_data (0: x, 1: y, 2: z);
// the user must write them only while the block is idle, which the block
// itself does not enforce.
module accel_tilt_angle_filter import atf_pkg::*; #(
    parameter int WINDOW_DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_accel_x,
    input  logic signed [SAMPLE_W-1:0] s_accel_y,
    input  logic signed [SAMPLE_W-1:0] s_accel_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CODE_W-1:0]          m_alpha_code,
    output logic [CODE_W-1:0]          m_beta_code,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [OFS_W-1:0]           cfg_data
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH+1);

    atf_cmd_t           cmd;
    logic [IDX_W-1:0]   wr_slot, rd_idx;
    logic [CNT_W-1:0]   fill;
    logic [STEP_W-1:0]  step;

    atf_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .wr_slot (wr_slot),
        .rd_idx  (rd_idx),
        .fill    (fill),
        .step    (step)
    );

    atf_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .wr_slot      (wr_slot),
        .rd_idx       (rd_idx),
        .fill         (fill),
        .step         (step),
        .s_accel_x    (s_accel_x),
        .s_accel_y    (s_accel_y),
        .s_accel_z    (s_accel_z),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_alpha_code (m_alpha_code),
        .m_beta_code  (m_beta_code)
    );

endmodule
